[rtl/pmst_pkg.sv]
// ----------------------------------------------------------------------------
// pmst_pkg
// Operation codes and default sizes of the pipeline memory stage.
// ----------------------------------------------------------------------------
`default_nettype none

package pmst_pkg;

  localparam int unsigned MemWordsDefault = 1024;
  localparam int unsigned DataWidth       = 32;

  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_LW    = 3'd1,
    OP_LB    = 3'd2,
    OP_SW    = 3'd3,
    OP_SB    = 3'd4,
    OP_LUI   = 3'd5,
    OP_ALU   = 3'd6,
    OP_OTHER = 3'd7
  } op_e;

  typedef logic [DataWidth-1:0] word_t;

endpackage

`default_nettype wire

[rtl/pipeline_memory_stage_top.sv]
// ----------------------------------------------------------------------------
// pipeline_memory_stage_top
// Memory stage: loads, stores and store forwarding on an internal word memory.
// ----------------------------------------------------------------------------
// An instruction is taken when start_i is high and busy_o is low; its result
// shows on the result ports, marked by result_valid_o for one cycle, once it
// has passed the s1 registers and the output registers. One instruction is
// taken in every cycle while busy_o is low: the address subtract and the
// memory read come first, the load/merge logic and the write after them,
// with a write-to-read bypass so back-to-back accesses to one word see each
// other. After reset busy_o stays high while the data memory is swept to
// zero, one word a cycle. The base address register may be written at any
// time, but only changes behavior safely while no instruction is in flight.
`default_nettype none

module pipeline_memory_stage_top #(
  parameter int unsigned MEM_WORDS = pmst_pkg::MemWordsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  pmst_pkg::word_t     cfg_data_i,

  input  logic                start_i,
  output logic                busy_o,
  input  logic [2:0]          operation_i,
  input  logic [4:0]          rt_index_i,
  input  logic [4:0]          rd_index_i,
  input  logic signed [31:0]  rt_value_i,
  input  logic [31:0]         alu_result_i,

  output logic                result_valid_o,
  output logic signed [31:0]  result_value_o,
  output logic [31:0]         alu_passed_o,
  output logic                forwarded_o,
  output logic                mem_read_o,
  output logic                mem_write_o,
  output logic                active_o,
  output logic                range_error_o
);
  import pmst_pkg::*;

  localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  // configuration
  word_t base_q;

  // memory clear sweep
  logic          clearing_q;
  logic [AW-1:0] clr_cnt_q;

  // first stage registers
  logic          s1_valid_q;
  op_e           s1_op_q;
  logic [4:0]    s1_rt_q;
  logic [4:0]    s1_rd_q;
  word_t         s1_rtv_q;
  word_t         s1_alu_q;
  logic [1:0]    s1_pos_q;
  logic [AW-1:0] s1_idx_q;
  logic          s1_inrange_q;
  word_t         rdata_q;
  logic          byp_hit_q;
  word_t         byp_data_q;

  // previous instruction
  op_e           prev_op_q;
  logic [4:0]    prev_rt_q;
  logic [4:0]    prev_rd_q;
  word_t         prev_result_q;
  word_t         prev_alu_q;

  word_t         mem [MEM_WORDS];

  logic          accept;
  word_t         addr;
  logic [29:0]   widx;
  logic          inrange;
  logic [AW-1:0] raddr;

  logic          mem_we;
  logic [AW-1:0] waddr;
  word_t         wdata;

  logic          is_store;
  logic          is_mem;
  logic          prev_load;
  logic          fwd;
  word_t         store_val;
  word_t         word;
  logic [4:0]    sh;
  logic [7:0]    byte_val;
  word_t         merged;
  word_t         result;
  logic          rd_flag;
  logic          wr_flag;
  logic          err;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = clearing_q;
  assign accept      = start_i && !clearing_q;

  assign addr    = alu_result_i - base_q;
  assign widx    = addr[31:2];
  assign inrange = widx < 30'(MEM_WORDS);
  assign raddr   = widx[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(MEM_WORDS - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q      <= op_e'(operation_i);
      s1_rt_q      <= rt_index_i;
      s1_rd_q      <= rd_index_i;
      s1_rtv_q     <= word_t'(rt_value_i);
      s1_alu_q     <= alu_result_i;
      s1_pos_q     <= addr[1:0];
      s1_idx_q     <= raddr;
      s1_inrange_q <= inrange;
    end
  end

  // data memory with a bypass for a write landing on the word being read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (accept) begin
      rdata_q    <= mem[raddr];
      byp_hit_q  <= mem_we && (waddr == raddr);
      byp_data_q <= wdata;
    end
  end

  always_comb begin
    is_store  = (s1_op_q == OP_SW) || (s1_op_q == OP_SB);
    is_mem    = is_store || (s1_op_q == OP_LW) || (s1_op_q == OP_LB);
    prev_load = prev_op_q inside {OP_LW, OP_LB, OP_LUI};

    fwd       = 1'b0;
    store_val = s1_rtv_q;
    if (is_store) begin
      if (prev_load && prev_rt_q == s1_rt_q) begin
        store_val = prev_result_q;
        fwd       = 1'b1;
      end else if (prev_op_q == OP_ALU && prev_rd_q == s1_rt_q) begin
        store_val = prev_alu_q;
        fwd       = 1'b1;
      end
    end

    word     = byp_hit_q ? byp_data_q : rdata_q;
    // big-endian byte order: byte 0 is the top byte
    sh       = {~s1_pos_q, 3'b000};
    byte_val = 8'(word >> sh);
    merged   = (word & ~(word_t'(8'hFF) << sh)) | (word_t'(store_val[7:0]) << sh);

    result  = s1_rtv_q;
    rd_flag = 1'b0;
    wr_flag = 1'b0;
    err     = 1'b0;
    wdata   = merged;
    if (is_mem && !s1_inrange_q) begin
      err = 1'b1;
    end else begin
      case (s1_op_q)
        OP_LW: begin
          result  = word;
          rd_flag = 1'b1;
        end
        OP_LB: begin
          result  = {{24{byte_val[7]}}, byte_val};
          rd_flag = 1'b1;
        end
        OP_SW: begin
          wdata   = store_val;
          wr_flag = 1'b1;
        end
        OP_SB: begin
          wr_flag = 1'b1;
        end
        OP_LUI: begin
          result = s1_alu_q;
        end
        default: begin
          result = s1_rtv_q;
        end
      endcase
    end

    mem_we = clearing_q || (s1_valid_q && wr_flag);
    waddr  = clearing_q ? clr_cnt_q : s1_idx_q;
    if (clearing_q) begin
      wdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_op_q     <= OP_NOP;
      prev_rt_q     <= '0;
      prev_rd_q     <= '0;
      prev_result_q <= '0;
      prev_alu_q    <= '0;
    end else if (s1_valid_q) begin
      prev_op_q     <= s1_op_q;
      prev_rt_q     <= s1_rt_q;
      prev_rd_q     <= s1_rd_q;
      prev_result_q <= result;
      prev_alu_q    <= s1_alu_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      result_value_o <= signed'(result);
      alu_passed_o   <= s1_alu_q;
      forwarded_o    <= fwd;
      mem_read_o     <= rd_flag;
      mem_write_o    <= wr_flag;
      active_o       <= (s1_op_q != OP_NOP);
      range_error_o  <= err;
    end
  end

`ifndef SYNTHESIS
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clearing_q |=> !clearing_q)
    else $error("memory clear restarted");

  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s1_valid_q)
    else $error("instruction in flight during memory clear");

  a_two_cycle_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 result_valid_o)
    else $error("result strobe missing two cycles after accept");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $countones({mem_read_o, mem_write_o, range_error_o}) <= 1)
    else $error("conflicting memory flags");

  a_fwd_only_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && forwarded_o) |-> (mem_write_o || range_error_o))
    else $error("forwarding flagged on a non-store");
`endif

endmodule

`default_nettype wire
